[design/assert_macros.svh]
// Assertion helpers used by the queue design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// A property that must hold at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
// A condition that must never be seen at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

[design/mf3_pkg.sv]
package mf3_pkg;

	// Configuration registers are this wide.
	localparam int REG_BITS = 10;
	// Row counters and the height limit.
	localparam int ROW_BITS = 10;
	localparam int MAX_HEIGHT = 512;
	// Depth of the queue between front and back; a power of two.
	localparam int QUEUE_DEPTH = 4;
	// Samples taken into one sort.
	localparam int WIN_SIZE = 9;

	typedef enum logic {
		OP_PIXEL = 1'b0,
		OP_FLUSH = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		REG_IMAGE_WIDTH  = 2'd0,
		REG_IMAGE_HEIGHT = 2'd1
	} reg_index_t;

	// How many window samples are inside the image.
	typedef enum logic [1:0] {
		SEL_NINE = 2'd0,
		SEL_SIX  = 2'd1,
		SEL_FOUR = 2'd2
	} sel_t;

	// Per-word control passed from front to back.
	typedef struct packed {
		logic emit;
		logic top_ok;
		logic bot_ok;
		logic left_ok;
		logic right_ok;
		logic last;
	} flags_t;

endpackage

[design/mf3_ram.sv]
module mf3_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [0:DEPTH-1];

	// One write port, one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[design/mf3_front.sv]
module mf3_front #(
	parameter int MAX_WIDTH    = 512,
	parameter int CHANNEL_BITS = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic                             s_tuser,
	input  logic [23:0]                      s_tdata,
	input  logic                             cfg_we,
	input  logic [1:0]                       cfg_index,
	input  logic [mf3_pkg::REG_BITS-1:0]     cfg_data,
	input  logic                             q_ready,
	output logic                             q_push,
	output mf3_pkg::flags_t                  q_flags,
	output logic [9*CHANNEL_BITS-1:0]        q_col
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int EW = ($clog2(MAX_WIDTH + 1) > mf3_pkg::REG_BITS) ?
		$clog2(MAX_WIDTH + 1) : mf3_pkg::REG_BITS;
	localparam int PW = 3 * CHANNEL_BITS;
	localparam int RB = mf3_pkg::ROW_BITS;

	logic [mf3_pkg::REG_BITS-1:0] width_q, height_q;
	logic [AW-1:0]                ic_q, oc_q;
	logic [RB-1:0]                irow_q, orow_q;
	logic [EW-1:0]                w_raw, w_eff, ic_inc, oc_inc;
	logic [RB-1:0]                h_eff;
	logic                         is_flush, take, emit, col_wrap;
	logic [PW-1:0]                pix;
	logic [CHANNEL_BITS+7:0]      r_ext, g_ext, b_ext;
	mf3_pkg::flags_t              flags;
	logic                         s1_v_q;
	logic [AW-1:0]                s1_addr_q;
	logic [PW-1:0]                s1_pix_q;
	mf3_pkg::flags_t              s1_flags_q;
	logic [2*PW-1:0]              ram_rdata;

	// Effective frame size: width clamped to the line store depth, height to MAX_HEIGHT.
	assign w_raw = EW'(width_q);
	assign w_eff = (w_raw < EW'(2)) ? EW'(2) :
		(w_raw > EW'(MAX_WIDTH)) ? EW'(MAX_WIDTH) : w_raw;
	assign h_eff = (height_q < RB'(2)) ? RB'(2) :
		(height_q > RB'(mf3_pkg::MAX_HEIGHT)) ? RB'(mf3_pkg::MAX_HEIGHT) : height_q;

	// Classify the incoming word against the input position.
	assign is_flush = (s_tuser == mf3_pkg::OP_FLUSH);
	assign take     = s_tvalid && s_tready &&
		((!is_flush && irow_q < h_eff) || (is_flush && irow_q >= h_eff));
	assign emit     = (irow_q > RB'(1)) || (irow_q == RB'(1) && ic_q != '0);
	assign ic_inc   = EW'(ic_q) + EW'(1);
	assign col_wrap = ic_inc >= w_eff;
	assign oc_inc   = EW'(oc_q) + EW'(1);

	// Samples keep their low channel bits; a flush carries zeros.
	assign r_ext = {{CHANNEL_BITS{1'b0}}, s_tdata[7:0]};
	assign g_ext = {{CHANNEL_BITS{1'b0}}, s_tdata[15:8]};
	assign b_ext = {{CHANNEL_BITS{1'b0}}, s_tdata[23:16]};
	assign pix   = is_flush ? '0 :
		{b_ext[CHANNEL_BITS-1:0], g_ext[CHANNEL_BITS-1:0], r_ext[CHANNEL_BITS-1:0]};

	// Which neighbors of the output pixel lie inside the image.
	always_comb begin
		flags.emit     = emit;
		flags.top_ok   = orow_q != '0;
		flags.bot_ok   = (orow_q + RB'(1)) < h_eff;
		flags.left_ok  = oc_q != '0;
		flags.right_ok = oc_inc < w_eff;
		flags.last     = !flags.bot_ok && !flags.right_ok;
	end

	// Registers, frame position counters and restart on configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= mf3_pkg::REG_BITS'(512);
			height_q <= mf3_pkg::REG_BITS'(512);
			ic_q     <= '0;
			irow_q   <= '0;
			oc_q     <= '0;
			orow_q   <= '0;
		end else if (cfg_we) begin
			if (cfg_index == mf3_pkg::REG_IMAGE_WIDTH) begin
				width_q <= cfg_data;
			end
			if (cfg_index == mf3_pkg::REG_IMAGE_WIDTH ||
					cfg_index == mf3_pkg::REG_IMAGE_HEIGHT) begin
				ic_q   <= '0;
				irow_q <= '0;
				oc_q   <= '0;
				orow_q <= '0;
			end
			if (cfg_index == mf3_pkg::REG_IMAGE_HEIGHT) begin
				height_q <= cfg_data;
			end
		end else if (take) begin
			if (emit && flags.last) begin
				ic_q   <= '0;
				irow_q <= '0;
				oc_q   <= '0;
				orow_q <= '0;
			end else begin
				if (col_wrap) begin
					ic_q   <= '0;
					irow_q <= irow_q + RB'(1);
				end else begin
					ic_q <= ic_q + AW'(1);
				end
				if (emit) begin
					if (!flags.right_ok) begin
						oc_q   <= '0;
						orow_q <= orow_q + RB'(1);
					end else begin
						oc_q <= oc_q + AW'(1);
					end
				end
			end
		end
	end

	// Stage 1 waits for the line store read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (take) begin
			s1_v_q <= 1'b1;
		end else if (q_push) begin
			s1_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			s1_addr_q  <= ic_q;
			s1_pix_q   <= pix;
			s1_flags_q <= flags;
		end
	end

	assign s_tready = !s1_v_q || q_ready;
	assign q_push   = s1_v_q && q_ready;
	assign q_flags  = s1_flags_q;
	// Column to the window: older row, newer row, new pixel.
	assign q_col    = {s1_pix_q, ram_rdata};

	// Both line stores share one entry: newer row high, older row low.
	mf3_ram #(
		.WIDTH(2 * PW),
		.DEPTH(MAX_WIDTH)
	) u_lines (
		.clk  (clk),
		.we   (q_push),
		.waddr(s1_addr_q),
		.wdata({s1_pix_q, ram_rdata[2*PW-1:PW]}),
		.re   (take),
		.raddr(ic_q),
		.rdata(ram_rdata)
	);

endmodule

[design/mf3_fifo.sv]
`include "assert_macros.svh"

module mf3_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             in_ready,
	input  logic             pop,
	output logic             out_valid,
	output logic [WIDTH-1:0] dout
);

	localparam int PTRW = $clog2(DEPTH);
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [0:DEPTH-1];
	logic [PTRW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNTW-1:0]  count_q;

	assign in_ready  = count_q != CNTW'(DEPTH);
	assign out_valid = count_q != '0;
	assign dout      = slot_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTRW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTRW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNTW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNTW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= din;
		end
	end

	`ASSERT_NEVER(a_overflow, clk, arst_n, push && count_q == CNTW'(DEPTH))
	`ASSERT_NEVER(a_underflow, clk, arst_n, pop && count_q == '0)
	`ASSERT_CLK(a_ptr_count, clk, arst_n, PTRW'(wr_ptr_q - rd_ptr_q) == PTRW'(count_q))
	`ASSERT_CLK(a_count_up, clk, arst_n, push && !pop |=> count_q == $past(count_q) + CNTW'(1))

endmodule

[design/mf3_back.sv]
module mf3_back #(
	parameter int CHANNEL_BITS = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      q_valid,
	output logic                      q_pop,
	input  mf3_pkg::flags_t           q_flags,
	input  logic [9*CHANNEL_BITS-1:0] q_col,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [23:0]               m_tdata,
	output logic                      m_tlast
);

	localparam int CB = CHANNEL_BITS;
	localparam int PW = 3 * CB;
	localparam int KW = CB + 1;
	localparam int NS = mf3_pkg::WIN_SIZE;

	logic [PW-1:0]    win_q   [0:2][0:2];
	logic [PW-1:0]    new_win [0:2][0:2];
	logic [KW-1:0]    key_in  [0:2][0:NS-1];
	logic [KW-1:0]    stg_key_q [0:NS][0:2][0:NS-1];
	logic             stg_v_q   [0:NS];
	mf3_pkg::sel_t    stg_sel_q [0:NS];
	logic             stg_last_q[0:NS];
	mf3_pkg::sel_t    sel_in;
	logic [2:0]       row_ok, col_ok;
	logic [CB-1:0]    med [0:2];
	logic             en;
	logic             out_v_q, out_last_q;
	logic [23:0]      out_data_q;
	logic [23:0]      out_data;

	// The whole back end holds while a finished word is not taken.
	assign en    = !out_v_q || m_tready;
	assign q_pop = en && q_valid;

	// Window after this word's shift: column 2 takes the new column.
	always_comb begin
		for (int rr = 0; rr < 3; rr++) begin
			new_win[rr][0] = win_q[rr][1];
			new_win[rr][1] = win_q[rr][2];
			new_win[rr][2] = q_col[rr*PW +: PW];
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			win_q <= new_win;
		end
	end

	// Sort keys: samples outside the image carry a high mark and sort last.
	always_comb begin
		row_ok = {q_flags.bot_ok, 1'b1, q_flags.top_ok};
		col_ok = {q_flags.right_ok, 1'b1, q_flags.left_ok};
		for (int ch = 0; ch < 3; ch++) begin
			for (int rr = 0; rr < 3; rr++) begin
				for (int cc = 0; cc < 3; cc++) begin
					key_in[ch][rr*3+cc] = (row_ok[rr] && col_ok[cc]) ?
						{1'b0, new_win[rr][cc][ch*CB +: CB]} : {1'b1, {CB{1'b0}}};
				end
			end
		end
		if (q_flags.top_ok && q_flags.bot_ok && q_flags.left_ok && q_flags.right_ok) begin
			sel_in = mf3_pkg::SEL_NINE;
		end else if ((!q_flags.top_ok || !q_flags.bot_ok) &&
				(!q_flags.left_ok || !q_flags.right_ok)) begin
			sel_in = mf3_pkg::SEL_FOUR;
		end else begin
			sel_in = mf3_pkg::SEL_SIX;
		end
	end

	// Sort entry stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stg_v_q[0] <= 1'b0;
		end else if (en) begin
			stg_v_q[0] <= q_pop && q_flags.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			stg_key_q[0]  <= key_in;
			stg_sel_q[0]  <= sel_in;
			stg_last_q[0] <= q_flags.last;
		end
	end

	// Odd-even transposition sort, one round per stage.
	for (genvar i = 0; i < NS; i++) begin : g_round
		logic [KW-1:0] nxt [0:2][0:NS-1];

		always_comb begin
			nxt = stg_key_q[i];
			for (int ch = 0; ch < 3; ch++) begin
				for (int j = i % 2; j < NS - 1; j += 2) begin
					if (stg_key_q[i][ch][j] > stg_key_q[i][ch][j+1]) begin
						nxt[ch][j]   = stg_key_q[i][ch][j+1];
						nxt[ch][j+1] = stg_key_q[i][ch][j];
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				stg_v_q[i+1] <= 1'b0;
			end else if (en) begin
				stg_v_q[i+1] <= stg_v_q[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				stg_key_q[i+1]  <= nxt;
				stg_sel_q[i+1]  <= stg_sel_q[i];
				stg_last_q[i+1] <= stg_last_q[i];
			end
		end
	end

	// Pick the middle value, or the floor mean of the two middle values.
	always_comb begin
		logic [CB:0]     sum;
		logic [CB+7:0]   ext;
		for (int ch = 0; ch < 3; ch++) begin
			case (stg_sel_q[NS])
				mf3_pkg::SEL_SIX: begin
					sum = {1'b0, stg_key_q[NS][ch][2][CB-1:0]} +
						{1'b0, stg_key_q[NS][ch][3][CB-1:0]};
				end
				mf3_pkg::SEL_FOUR: begin
					sum = {1'b0, stg_key_q[NS][ch][1][CB-1:0]} +
						{1'b0, stg_key_q[NS][ch][2][CB-1:0]};
				end
				default: begin
					sum = {stg_key_q[NS][ch][4][CB-1:0], 1'b0};
				end
			endcase
			med[ch] = sum[CB:1];
			ext = {8'b0, med[ch]};
			out_data[ch*8 +: 8] = ext[7:0];
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= stg_v_q[NS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data_q <= out_data;
			out_last_q <= stg_last_q[NS];
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

endmodule

[design/median_filter_3x3_rgb.sv]
// Channel   Signals                          Contents
// s         s_tvalid s_tready s_tdata s_tuser pixel or flush word in raster order
// m         m_tvalid m_tready m_tdata m_tlast filtered pixel, last of frame
// cfg       cfg_we cfg_index cfg_data         image width (0), image height (1)
//
// One word is taken per clock while the queue has room; a result's column word passes
// the line store read, the 9-round sort pipeline and the output register.
// Results trail pixels by one row plus one pixel; width+1 flush words drain a frame.
// Reset clears counters and valid bits; line stores need no clearing.
// The front and back stall on their own through a four-word queue.
module median_filter_3x3_rgb #(
	parameter int MAX_WIDTH    = 512,
	parameter int CHANNEL_BITS = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [23:0]                  s_tdata,  // red, green, blue
	input  logic                         s_tuser,  // opcode
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [23:0]                  m_tdata,  // out_red, out_green, out_blue
	output logic                         m_tlast,
	input  logic                         cfg_we,
	input  logic [1:0]                   cfg_index,
	input  logic [mf3_pkg::REG_BITS-1:0] cfg_data
);

	localparam int CW = 9 * CHANNEL_BITS;
	localparam int FW = $bits(mf3_pkg::flags_t);

	logic            q_push, q_ready, q_valid, q_pop;
	mf3_pkg::flags_t f_flags, b_flags;
	logic [CW-1:0]   f_col, b_col;

	// Counters, classification and line stores.
	mf3_front #(
		.MAX_WIDTH   (MAX_WIDTH),
		.CHANNEL_BITS(CHANNEL_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.q_ready  (q_ready),
		.q_push   (q_push),
		.q_flags  (f_flags),
		.q_col    (f_col)
	);

	// Queue between front and back.
	mf3_fifo #(
		.WIDTH(FW + CW),
		.DEPTH(mf3_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.din      ({f_flags, f_col}),
		.in_ready (q_ready),
		.pop      (q_pop),
		.out_valid(q_valid),
		.dout     ({b_flags, b_col})
	);

	// Window, sort and output.
	mf3_back #(
		.CHANNEL_BITS(CHANNEL_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_pop   (q_pop),
		.q_flags (b_flags),
		.q_col   (b_col),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

endmodule

[dv/tb_median_filter_3x3_rgb.sv]
`timescale 1ns / 100ps

module tb_median_filter_3x3_rgb;

	localparam int MAX_W = 512;
	localparam int DRAIN_CYCLES = 40;

	typedef struct {
		mf3_pkg::opcode_t op;
		logic [23:0]      rgb;
	} in_word_t;

	typedef struct {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic       last;
	} out_word_t;

	logic                         clk;
	logic                         arst_n;
	logic                         s_tvalid;
	logic                         s_tready;
	logic [23:0]                  s_tdata;  // red, green, blue
	logic                         s_tuser;  // opcode
	logic                         m_tvalid;
	logic                         m_tready;
	logic [23:0]                  m_tdata;  // out_red, out_green, out_blue
	logic                         m_tlast;
	logic                         cfg_we;
	logic [1:0]                   cfg_index;
	logic [mf3_pkg::REG_BITS-1:0] cfg_data;

	median_filter_3x3_rgb DUT (.*);

	// Words waiting to be sent and filtered pixels still to arrive.
	in_word_t  word_feed[$];
	out_word_t filtered_due[$];
	int        errors = 0;
	int        tx_idle_pct = 34;
	int        rx_idle_pct = 88;
	int        words_made = 0;

	// Shadow of the filter state.
	logic [mf3_pkg::REG_BITS-1:0] width_reg;
	logic [mf3_pkg::REG_BITS-1:0] height_reg;
	logic [23:0] older_line[MAX_W];
	logic [23:0] newer_line[MAX_W];
	logic [23:0] win[3][3];
	int          in_col, in_row, out_col, out_row;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int clamp_size(input logic [mf3_pkg::REG_BITS-1:0] v, input int hi);
		if (v < 2) return 2;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic void restart_window();
		in_col = 0;
		in_row = 0;
		out_col = 0;
		out_row = 0;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				win[i][j] = '0;
	endfunction

	function automatic void shadow_config(input mf3_pkg::reg_index_t idx,
			input logic [mf3_pkg::REG_BITS-1:0] v);
		if (idx == mf3_pkg::REG_IMAGE_WIDTH) begin
			width_reg = v;
			restart_window();
		end else if (idx == mf3_pkg::REG_IMAGE_HEIGHT) begin
			height_reg = v;
			restart_window();
		end
	endfunction

	// Median of n samples; an even count gives the floor of the two middle samples' mean.
	function automatic logic [7:0] median_n(input int vals[9], input int n);
		int t;
		int j;
		for (int i = 1; i < n; i++) begin
			t = vals[i];
			j = i;
			while (j > 0 && vals[j-1] > t) begin
				vals[j] = vals[j-1];
				j--;
			end
			vals[j] = t;
		end
		if (n % 2) return vals[n/2];
		return (vals[n/2-1] + vals[n/2]) >> 1;
	endfunction

	// Advance the shadow by one accepted word; returns 1 when a filtered pixel is due.
	function automatic bit filter_word(input in_word_t wd, output out_word_t res);
		int w;
		int h;
		int ic;
		int vals[9];
		int n;
		bit emit;
		bit row_ok[3];
		bit col_ok[3];
		logic [23:0] p;
		logic [7:0] med[3];
		w = clamp_size(width_reg, MAX_W);
		h = clamp_size(height_reg, mf3_pkg::MAX_HEIGHT);
		ic = in_col;
		res = '{default: '0};
		if (wd.op == mf3_pkg::OP_PIXEL && in_row >= h) return 0;
		if (wd.op == mf3_pkg::OP_FLUSH && in_row < h) return 0;
		p = (wd.op == mf3_pkg::OP_FLUSH) ? 24'd0 : wd.rgb;
		for (int rr = 0; rr < 3; rr++) begin
			win[rr][0] = win[rr][1];
			win[rr][1] = win[rr][2];
		end
		win[0][2] = older_line[ic];
		win[1][2] = newer_line[ic];
		win[2][2] = p;
		older_line[ic] = newer_line[ic];
		newer_line[ic] = p;
		emit = in_row > 1 || (in_row == 1 && ic >= 1);
		if (ic + 1 >= w) begin
			in_col = 0;
			in_row++;
		end else begin
			in_col = ic + 1;
		end
		if (!emit) return 0;
		row_ok = '{out_row > 0, 1'b1, out_row + 1 < h};
		col_ok = '{out_col > 0, 1'b1, out_col + 1 < w};
		for (int ch = 0; ch < 3; ch++) begin
			n = 0;
			for (int rr = 0; rr < 3; rr++)
				for (int cc = 0; cc < 3; cc++)
					if (row_ok[rr] && col_ok[cc]) begin
						vals[n] = win[rr][cc][ch*8 +: 8];
						n++;
					end
			med[ch] = median_n(vals, n);
		end
		res.r = med[0];
		res.g = med[1];
		res.b = med[2];
		res.last = (out_row + 1 >= h) && (out_col + 1 >= w);
		if (res.last) begin
			restart_window();
		end else if (out_col + 1 >= w) begin
			out_col = 0;
			out_row++;
		end else begin
			out_col++;
		end
		return 1;
	endfunction

	// Sender: hold a word until taken, then pick the next one or idle.
	always @(posedge clk or negedge arst_n) begin
		in_word_t wd;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= mf3_pkg::OP_PIXEL;
		end else if (!s_tvalid || s_tready) begin
			if (word_feed.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
				wd = word_feed.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= wd.rgb;
				s_tuser <= wd.op;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver backpressure.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
	end

	// Predict on each accepted input word.
	always @(posedge clk) begin
		in_word_t  wd;
		out_word_t res;
		if (arst_n && s_tvalid && s_tready) begin
			wd.op = mf3_pkg::opcode_t'(s_tuser);
			wd.rgb = s_tdata;
			if (filter_word(wd, res))
				filtered_due.push_back(res);
		end
	end

	// Compare each accepted output word with the oldest prediction.
	always @(posedge clk) begin
		out_word_t ex;
		if (arst_n && m_tvalid && m_tready) begin
			if (filtered_due.size() == 0) begin
				$error("unexpected output word %h last %b", m_tdata, m_tlast);
				errors++;
			end else begin
				ex = filtered_due.pop_front();
				if (m_tdata[7:0] !== ex.r) begin
					$error("out_red expected %0d actual %0d", ex.r, m_tdata[7:0]);
					errors++;
				end
				if (m_tdata[15:8] !== ex.g) begin
					$error("out_green expected %0d actual %0d", ex.g, m_tdata[15:8]);
					errors++;
				end
				if (m_tdata[23:16] !== ex.b) begin
					$error("out_blue expected %0d actual %0d", ex.b, m_tdata[23:16]);
					errors++;
				end
				if (m_tlast !== ex.last) begin
					$error("frame_end expected %0d actual %0d", ex.last, m_tlast);
					errors++;
				end
			end
		end
	end

	task automatic wait_quiet();
		while (word_feed.size() > 0 || s_tvalid || filtered_due.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [mf3_pkg::REG_BITS-1:0] v);
		wait_quiet();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		shadow_config(mf3_pkg::reg_index_t'(idx), v);
	endtask

	task automatic push_word(input mf3_pkg::opcode_t op, input logic [23:0] rgb);
		word_feed.push_back('{op, rgb});
		words_made++;
	endtask

	// One frame: pixels, then the flush words that drain the tail. With noise, a stray
	// flush before the last pixel, a stray pixel after it and a flush past the drain.
	task automatic send_frame(input int w, input int h, input bit noisy, input bit extremes,
			input int pixels = -1);
		logic [23:0] px;
		int npix;
		npix = (pixels < 0) ? w * h : pixels;
		for (int i = 0; i < npix; i++) begin
			if (noisy && i == w * h - 1)
				push_word(mf3_pkg::OP_FLUSH, $urandom);
			if (extremes)
				px = {$urandom_range(1) ? 8'hFF : 8'h00, $urandom_range(1) ? 8'hFF : 8'h00,
					$urandom_range(1) ? 8'hFF : 8'h00};
			else
				px = $urandom;
			push_word(mf3_pkg::OP_PIXEL, px);
		end
		if (pixels >= 0) return;
		if (noisy)
			push_word(mf3_pkg::OP_PIXEL, $urandom);
		for (int i = 0; i <= w; i++)
			push_word(mf3_pkg::OP_FLUSH, $urandom);
		if (noisy)
			push_word(mf3_pkg::OP_FLUSH, $urandom);
	endtask

	// A frame of the given register values; a pixel count cuts it short.
	task automatic sized_frame(input logic [mf3_pkg::REG_BITS-1:0] wv,
			input logic [mf3_pkg::REG_BITS-1:0] hv, input bit noisy, input int pixels = -1);
		write_reg(mf3_pkg::REG_IMAGE_WIDTH, wv);
		write_reg(mf3_pkg::REG_IMAGE_HEIGHT, hv);
		send_frame(clamp_size(wv, MAX_W), clamp_size(hv, mf3_pkg::MAX_HEIGHT), noisy, 1'b0,
			pixels);
	endtask

	// Stimulus.
	initial begin
		int target;
		logic [mf3_pkg::REG_BITS-1:0] wv;
		logic [mf3_pkg::REG_BITS-1:0] hv;
		width_reg = 512;
		height_reg = 512;
		for (int i = 0; i < MAX_W; i++) begin
			older_line[i] = '0;
			newer_line[i] = '0;
		end
		restart_window();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: smallest frame with extreme samples, out-of-range sizes, stray words,
		// unused register indices and a restart in the middle of a frame.
		write_reg(mf3_pkg::REG_IMAGE_WIDTH, 10'd0);
		write_reg(mf3_pkg::REG_IMAGE_HEIGHT, 10'd1);
		send_frame(2, 2, 1'b1, 1'b1);
		write_reg(mf3_pkg::REG_IMAGE_WIDTH, 10'd3);
		write_reg(mf3_pkg::REG_IMAGE_HEIGHT, 10'd3);
		write_reg(2'd2, 10'd7);
		write_reg(2'd3, 10'h3FF);
		send_frame(3, 3, 1'b0, 1'b1);
		send_frame(3, 3, 1'b0, 1'b1, 5);
		write_reg(mf3_pkg::REG_IMAGE_HEIGHT, 10'd2);
		send_frame(3, 2, 1'b0, 1'b1);

		// Random frames under three idle patterns.
		for (int ph = 0; ph < 3; ph++) begin
			wait_quiet();
			tx_idle_pct = (ph == 0) ? 34 : (ph == 1) ? 88 : 0;
			rx_idle_pct = (ph == 0) ? 88 : (ph == 1) ? 34 : 0;
			if (ph == 2) begin
				// Oversized width: the first row wraps at the line store depth.
				sized_frame(10'h3FF, 10'd2, 1'b0, 516);
				sized_frame(10'd2, 10'h3FF, 1'b0, 24);
			end
			target = words_made + 60;
			while (words_made < target) begin
				case ($urandom_range(19))
					0: wv = $urandom_range(1);
					1: wv = $urandom_range(9, 40);
					default: wv = $urandom_range(2, 8);
				endcase
				case ($urandom_range(19))
					0: hv = $urandom_range(1);
					1: hv = $urandom_range(6, 12);
					default: hv = $urandom_range(2, 5);
				endcase
				if (wv > 8 && hv > 5)
					hv = 3;
				sized_frame(wv, hv, $urandom_range(3) == 0);
			end
		end

		wait_quiet();
		if (errors == 0)
			$display("** median_filter_3x3_rgb: PASSED **");
		else
			$display("** median_filter_3x3_rgb: FAILED **");
		$finish;
	end

	// Run limit.
	initial begin
		#20ms;
		$display("** median_filter_3x3_rgb: FAILED **");
		$finish;
	end

endmodule
